// File: hw/rtl/owm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types and constants of the tick-driven word bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int unsigned TIME_W = 8;
    localparam int unsigned DATA_W = 16;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        OP_NOP   = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } owm_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_LOW   = 3'd0,
        REG_PRES_DELAY  = 3'd1,
        REG_RECOVER     = 3'd2,
        REG_SHORT_LOW   = 3'd3,
        REG_LONG_LOW    = 3'd4,
        REG_SLOT_LEN    = 3'd5,
        REG_READ_SAMPLE = 3'd6,
        REG_READ_SLOT   = 3'd7
    } owm_reg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_RST_WAIT  = 3'd2,
        PH_RST_RECOV = 3'd3,
        PH_WRITE     = 3'd4,
        PH_READ      = 3'd5,
        PH_READ_WAIT = 3'd6
    } owm_phase_t;

    localparam logic [TIME_W-1:0] DEF_RESET_LOW   = 8'd100;
    localparam logic [TIME_W-1:0] DEF_PRES_DELAY  = 8'd16;
    localparam logic [TIME_W-1:0] DEF_RECOVER     = 8'd90;
    localparam logic [TIME_W-1:0] DEF_SHORT_LOW   = 8'd2;
    localparam logic [TIME_W-1:0] DEF_LONG_LOW    = 8'd11;
    localparam logic [TIME_W-1:0] DEF_SLOT_LEN    = 8'd15;
    localparam logic [TIME_W-1:0] DEF_READ_SAMPLE = 8'd4;
    localparam logic [TIME_W-1:0] DEF_READ_SLOT   = 8'd12;

    typedef struct packed {
        owm_op_t            op;
        logic [DATA_W-1:0]  write_data;
        logic               line_in;
    } owm_in_t;

    typedef struct packed {
        logic               drive_low;
        logic               busy_res;
        logic               done_res;
        logic               presence;
        logic [DATA_W-1:0]  read_word;
    } owm_out_t;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_ticks;
        logic [TIME_W-1:0] presence_delay;
        logic [TIME_W-1:0] reset_recover;
        logic [TIME_W-1:0] short_low;
        logic [TIME_W-1:0] long_low;
        logic [TIME_W-1:0] slot_len;
        logic [TIME_W-1:0] read_sample;
        logic [TIME_W-1:0] read_end;   // max of read_sample, read_slot, short_low
    } owm_cfg_t;

endpackage
`default_nettype wire

// File: hw/rtl/owm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owm_cfg_regs
// Timing register file with write port; also derives the read slot end tick.
// ----------------------------------------------------------------------------
module owm_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owm_pkg::TIME_W-1:0]     cfg_wdata,
    output owm_pkg::owm_cfg_t                   cfg
);

    logic [owm_pkg::TIME_W-1:0] reset_low_reg,   reset_low_next;
    logic [owm_pkg::TIME_W-1:0] pres_delay_reg,  pres_delay_next;
    logic [owm_pkg::TIME_W-1:0] recover_reg,     recover_next;
    logic [owm_pkg::TIME_W-1:0] short_low_reg,   short_low_next;
    logic [owm_pkg::TIME_W-1:0] long_low_reg,    long_low_next;
    logic [owm_pkg::TIME_W-1:0] slot_len_reg,    slot_len_next;
    logic [owm_pkg::TIME_W-1:0] read_sample_reg, read_sample_next;
    logic [owm_pkg::TIME_W-1:0] read_slot_reg,   read_slot_next;
    logic [owm_pkg::TIME_W-1:0] max_a;
    owm_pkg::owm_reg_idx_t      idx;

    assign idx = owm_pkg::owm_reg_idx_t'(cfg_index);

    always_comb begin
        reset_low_next   = reset_low_reg;
        pres_delay_next  = pres_delay_reg;
        recover_next     = recover_reg;
        short_low_next   = short_low_reg;
        long_low_next    = long_low_reg;
        slot_len_next    = slot_len_reg;
        read_sample_next = read_sample_reg;
        read_slot_next   = read_slot_reg;
        if (cfg_wr_en) begin
            case (idx)
                owm_pkg::REG_RESET_LOW:   reset_low_next   = cfg_wdata;
                owm_pkg::REG_PRES_DELAY:  pres_delay_next  = cfg_wdata;
                owm_pkg::REG_RECOVER:     recover_next     = cfg_wdata;
                owm_pkg::REG_SHORT_LOW:   short_low_next   = cfg_wdata;
                owm_pkg::REG_LONG_LOW:    long_low_next    = cfg_wdata;
                owm_pkg::REG_SLOT_LEN:    slot_len_next    = cfg_wdata;
                owm_pkg::REG_READ_SAMPLE: read_sample_next = cfg_wdata;
                owm_pkg::REG_READ_SLOT:   read_slot_next   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_low_reg   <= owm_pkg::DEF_RESET_LOW;
            pres_delay_reg  <= owm_pkg::DEF_PRES_DELAY;
            recover_reg     <= owm_pkg::DEF_RECOVER;
            short_low_reg   <= owm_pkg::DEF_SHORT_LOW;
            long_low_reg    <= owm_pkg::DEF_LONG_LOW;
            slot_len_reg    <= owm_pkg::DEF_SLOT_LEN;
            read_sample_reg <= owm_pkg::DEF_READ_SAMPLE;
            read_slot_reg   <= owm_pkg::DEF_READ_SLOT;
        end else begin
            reset_low_reg   <= reset_low_next;
            pres_delay_reg  <= pres_delay_next;
            recover_reg     <= recover_next;
            short_low_reg   <= short_low_next;
            long_low_reg    <= long_low_next;
            slot_len_reg    <= slot_len_next;
            read_sample_reg <= read_sample_next;
            read_slot_reg   <= read_slot_next;
        end
    end

    assign max_a = (read_slot_reg > read_sample_reg) ? read_slot_reg : read_sample_reg;

    always_comb begin
        cfg.reset_low_ticks = reset_low_reg;
        cfg.presence_delay  = pres_delay_reg;
        cfg.reset_recover   = recover_reg;
        cfg.short_low       = short_low_reg;
        cfg.long_low        = long_low_reg;
        cfg.slot_len        = slot_len_reg;
        cfg.read_sample     = read_sample_reg;
        cfg.read_end        = (short_low_reg > max_a) ? short_low_reg : max_a;
    end

endmodule
`default_nettype wire

// File: hw/rtl/owm_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owm_seq
// Bus sequencer: phase, tick counter, bit counter and shift word, stepped once
// per beat; produces the per-tick result.
// ----------------------------------------------------------------------------
module owm_seq #(
    parameter int unsigned WORD_BITS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire owm_pkg::owm_in_t  in_beat,
    input  wire owm_pkg::owm_cfg_t cfg,
    output owm_pkg::owm_out_t res
);

    localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);
    localparam int unsigned IDX_W = $clog2(WORD_BITS);
    localparam int unsigned TW = owm_pkg::TIME_W;
    localparam int unsigned DW = owm_pkg::DATA_W;

    owm_pkg::owm_phase_t    phase_reg, phase_next, eff_phase;
    logic [TW-1:0]          tick_reg, tick_next, t;
    logic [CNT_W-1:0]       bit_reg, bit_next, eff_bit, bit_plus;
    logic [WORD_BITS-1:0]   shift_reg, shift_next, eff_shift, rd_shift, rd_mask;
    logic                   pres_reg, pres_next;
    logic [DW-1:0]          recv_reg, recv_next;
    logic                   start, word_end, line;
    logic [TW:0]            t_plus;
    logic [TW-1:0]          wr_low;
    logic                   hit_rst_low, hit_pres, hit_recov, hit_slot;
    logic                   rd_end, rd_sample;
    logic [WORD_BITS+DW-1:0] wd_wide, rd_wide;

    assign line  = in_beat.line_in;
    assign start = (phase_reg == owm_pkg::PH_IDLE) && (in_beat.op != owm_pkg::OP_NOP);

    assign wd_wide = {{WORD_BITS{1'b0}}, in_beat.write_data};
    assign rd_wide = {{DW{1'b0}}, rd_shift};

    always_comb begin
        eff_phase = phase_reg;
        eff_shift = shift_reg;
        if (start) begin
            case (in_beat.op)
                owm_pkg::OP_RESET: eff_phase = owm_pkg::PH_RST_LOW;
                owm_pkg::OP_WRITE: begin
                    eff_phase = owm_pkg::PH_WRITE;
                    eff_shift = wd_wide[WORD_BITS-1:0];
                end
                owm_pkg::OP_READ: begin
                    eff_phase = owm_pkg::PH_READ;
                    eff_shift = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign t       = start ? '0 : tick_reg;
    assign eff_bit = start ? '0 : bit_reg;

    assign t_plus      = {1'b0, t} + {{TW{1'b0}}, 1'b1};
    assign hit_rst_low = t_plus >= {1'b0, cfg.reset_low_ticks};
    assign hit_pres    = t_plus >= {1'b0, cfg.presence_delay};
    assign hit_recov   = t_plus >= {1'b0, cfg.reset_recover};
    assign hit_slot    = t_plus >= {1'b0, cfg.slot_len};
    assign wr_low      = eff_shift[0] ? cfg.short_low : cfg.long_low;
    assign bit_plus    = eff_bit + {{(CNT_W-1){1'b0}}, 1'b1};
    assign word_end    = bit_plus >= CNT_W'(WORD_BITS);
    assign rd_end      = t >= cfg.read_end;
    // the bit is taken only inside the slot proper, never while waiting for the line
    assign rd_sample   = (eff_phase == owm_pkg::PH_READ) && (t == cfg.read_sample) && line;
    assign rd_mask     = {{(WORD_BITS-1){1'b0}}, 1'b1} << eff_bit[IDX_W-1:0];
    assign rd_shift    = rd_sample ? (eff_shift | rd_mask) : eff_shift;

    // next state
    always_comb begin
        phase_next = eff_phase;
        tick_next  = t;
        bit_next   = eff_bit;
        shift_next = eff_shift;
        pres_next  = pres_reg;
        recv_next  = recv_reg;
        case (eff_phase)
            owm_pkg::PH_IDLE: begin
            end
            owm_pkg::PH_RST_LOW: begin
                if (hit_rst_low) begin
                    phase_next = owm_pkg::PH_RST_WAIT;
                    tick_next  = '0;
                end else begin
                    tick_next = t_plus[TW-1:0];
                end
            end
            owm_pkg::PH_RST_WAIT: begin
                if (hit_pres) begin
                    pres_next  = ~line;
                    phase_next = owm_pkg::PH_RST_RECOV;
                    tick_next  = '0;
                end else begin
                    tick_next = t_plus[TW-1:0];
                end
            end
            owm_pkg::PH_RST_RECOV: begin
                if (hit_recov) begin
                    phase_next = owm_pkg::PH_IDLE;
                    tick_next  = '0;
                end else begin
                    tick_next = t_plus[TW-1:0];
                end
            end
            owm_pkg::PH_WRITE: begin
                if (hit_slot) begin
                    shift_next = eff_shift >> 1;
                    tick_next  = '0;
                    if (word_end) begin
                        phase_next = owm_pkg::PH_IDLE;
                        bit_next   = '0;
                    end else begin
                        bit_next = bit_plus;
                    end
                end else begin
                    tick_next = t_plus[TW-1:0];
                end
            end
            owm_pkg::PH_READ, owm_pkg::PH_READ_WAIT: begin
                shift_next = rd_shift;
                if (eff_phase == owm_pkg::PH_READ && !rd_end) begin
                    tick_next = t_plus[TW-1:0];
                end else if (line) begin
                    tick_next = '0;
                    if (word_end) begin
                        recv_next  = rd_wide[DW-1:0];
                        phase_next = owm_pkg::PH_IDLE;
                        bit_next   = '0;
                    end else begin
                        phase_next = owm_pkg::PH_READ;
                        bit_next   = bit_plus;
                    end
                end else begin
                    phase_next = owm_pkg::PH_READ_WAIT;
                end
            end
            default: begin
                phase_next = owm_pkg::PH_IDLE;
                tick_next  = '0;
                bit_next   = '0;
            end
        endcase
    end

    // per-tick outputs
    always_comb begin
        res.drive_low = 1'b0;
        res.busy_res  = 1'b1;
        res.done_res  = 1'b0;
        case (eff_phase)
            owm_pkg::PH_IDLE:      res.busy_res  = 1'b0;
            owm_pkg::PH_RST_LOW:   res.drive_low = 1'b1;
            owm_pkg::PH_RST_WAIT: begin
            end
            owm_pkg::PH_RST_RECOV: res.done_res  = hit_recov;
            owm_pkg::PH_WRITE: begin
                res.drive_low = t < wr_low;
                res.done_res  = hit_slot && word_end;
            end
            owm_pkg::PH_READ: begin
                res.drive_low = t < cfg.short_low;
                res.done_res  = rd_end && line && word_end;
            end
            owm_pkg::PH_READ_WAIT: res.done_res = line && word_end;
            default:               res.busy_res = 1'b0;
        endcase
        res.presence  = pres_next;
        res.read_word = recv_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owm_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            recv_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            recv_reg  <= recv_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == owm_pkg::PH_IDLE |-> (tick_reg == '0 && bit_reg == '0))
        else $error("idle with nonzero counters");

    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_reg < CNT_W'(WORD_BITS))
        else $error("bit counter out of range");

    a_wait_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && phase_reg == owm_pkg::PH_READ_WAIT && !in_beat.line_in
        |=> phase_reg == owm_pkg::PH_READ_WAIT)
        else $error("read wait left while line low");

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && res.done_res |=> phase_reg == owm_pkg::PH_IDLE)
        else $error("command done but sequencer not idle");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/onewire_word_master_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_word_master_core
// Tick-driven open-drain bus master for reset, word write and word read.
// ----------------------------------------------------------------------------
// Every input beat is one bus tick and yields exactly one result beat. The core
// takes one beat per clock cycle while the result side does not stall; a beat
// passes an input register and then the result register before its result is
// offered. Timing registers are written through the cfg_wr_en port and take
// effect from the next cycle; write them only while no command is running.
module onewire_word_master_core #(
    parameter int unsigned WORD_BITS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire owm_pkg::owm_in_t               s_payload,
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output owm_pkg::owm_out_t                   m_payload,
    input  wire logic                           cfg_wr_en,
    input  wire logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owm_pkg::TIME_W-1:0]     cfg_wdata
);

    logic               in_vld_reg, in_vld_next;
    owm_pkg::owm_in_t   in_data_reg;
    logic               out_vld_reg, out_vld_next;
    owm_pkg::owm_out_t  out_data_reg;
    owm_pkg::owm_out_t  step_res;
    owm_pkg::owm_cfg_t  cfg;
    logic               adv, s_fire;

    owm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owm_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (adv),
        .in_beat (in_data_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (adv) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (adv) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_payload;
        end
        if (adv) begin
            out_data_reg <= step_res;
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_payload = out_data_reg;

endmodule
`default_nettype wire
